@@ rtl/hsv_pkg.sv @@
// shared constants and types for the hsv to rgb565 converter
package hsv_pkg;

    // angle constants
    localparam logic [8:0]  HUE_TURN   = 9'd360;
    localparam logic [5:0]  SECTOR_DEG = 6'd60;

    // level one in q1.8 and the full numerator v * 60 for v = 1.0
    localparam logic [8:0]  LEVEL_ONE  = 9'd256;
    localparam logic [13:0] FULL_NUM   = 14'd15360;

    // largest numerator over the common denominator 256 * 256 * 60
    localparam logic [21:0] MAX_NUM    = 22'd3932160;

    // reciprocal constants: hue / 360 as (hue * 46604) >> 24,
    // hue / 60 as (hue * 1093) >> 16, x / 15 as (x * 4370) >> 16
    localparam logic [15:0] HUE_RECIP   = 16'd46604;
    localparam logic [10:0] SECT_RECIP  = 11'd1093;
    localparam logic [12:0] DIV15_RECIP = 13'd4370;

    // output scales
    localparam logic [4:0]  SCALE5 = 5'd31;
    localparam logic [5:0]  SCALE6 = 6'd63;

    typedef logic [8:0]  level_t;
    typedef logic [21:0] num_t;

    // 60 degree sectors of the colour wheel
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    // hue split into sector and remainder, levels clamped
    typedef struct packed {
        sector_t sector;
        logic [5:0] frac;
        level_t sat;
        level_t bright;
    } hsv_split_t;

    // component numerators over the common denominator
    typedef struct packed {
        num_t red_num;
        num_t green_num;
        num_t blue_num;
    } rgb_num_t;

endpackage

@@ rtl/hsv_if.sv @@
// valid/ready channel interfaces for hsv input and rgb565 output

interface hsv_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] hue_degrees;
    logic [8:0]  sat_level;
    logic [8:0]  bright_level;

    modport source (output valid, output hue_degrees, output sat_level,
                    output bright_level, input ready);
    modport sink (input valid, input hue_degrees, input sat_level,
                  input bright_level, output ready);
endinterface

interface rgb_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] red;
    logic [5:0] green;
    logic [4:0] blue;

    modport source (output valid, output red, output green, output blue,
                    input ready);
    modport sink (input valid, input red, input green, input blue,
                  output ready);
endinterface

@@ rtl/hsv_hue_split.sv @@
// four stage hue reduction: modulo 360, then sector and remainder
module hsv_hue_split
    import hsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hsv_in_if.sink     hsv_in,
    output logic       split_valid,
    input  logic       split_ready,
    output hsv_split_t split_data
);

    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic [15:0] hue1_reg;
    logic [7:0]  quot_reg;
    level_t      sat1_reg, bright1_reg;
    logic [8:0]  hue2_reg;
    level_t      sat2_reg, bright2_reg;
    logic [8:0]  hue3_reg;
    sector_t     sector3_reg;
    level_t      sat3_reg, bright3_reg;
    hsv_split_t  split_reg;

    logic [31:0] hue_prod;
    logic [7:0]  quot_next;
    level_t      sat_next, bright_next;
    logic [15:0] quot_deg;
    logic [15:0] hue_diff;
    logic [8:0]  hue2_next;
    logic [19:0] sect_prod;
    sector_t     sector_next;
    logic [8:0]  sect_deg;
    logic [8:0]  frac_diff;
    hsv_split_t  split_next;

    // stage enables, a stage loads when empty or when its contents move on
    assign rdy4 = !vld4_reg || split_ready;
    assign rdy3 = !vld3_reg || rdy4;
    assign rdy2 = !vld2_reg || rdy3;
    assign rdy1 = !vld1_reg || rdy2;
    assign hsv_in.ready = rdy1;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                vld1_reg <= hsv_in.valid;
            end
            if (rdy2)
            begin
                vld2_reg <= vld1_reg;
            end
            if (rdy3)
            begin
                vld3_reg <= vld2_reg;
            end
            if (rdy4)
            begin
                vld4_reg <= vld3_reg;
            end
        end
    end

    // stage 1: quotient of hue by 360, clamp levels to one
    assign hue_prod    = 32'(hsv_in.hue_degrees) * 32'(HUE_RECIP);
    assign quot_next   = hue_prod[31:24];
    assign sat_next    = (hsv_in.sat_level > LEVEL_ONE) ? LEVEL_ONE : hsv_in.sat_level;
    assign bright_next = (hsv_in.bright_level > LEVEL_ONE) ? LEVEL_ONE
                                                           : hsv_in.bright_level;

    // stage 2: remainder of hue by 360
    assign quot_deg  = 16'(quot_reg) * 16'(HUE_TURN);
    assign hue_diff  = hue1_reg - quot_deg;
    assign hue2_next = hue_diff[8:0];

    // stage 3: sector from reduced hue
    assign sect_prod   = 20'(hue2_reg) * 20'(SECT_RECIP);
    assign sector_next = sector_t'(sect_prod[18:16]);

    // stage 4: remainder within the sector
    assign sect_deg  = 9'(sector3_reg) * 9'(SECTOR_DEG);
    assign frac_diff = hue3_reg - sect_deg;

    always_comb
    begin
        split_next.sector = sector3_reg;
        split_next.frac   = frac_diff[5:0];
        split_next.sat    = sat3_reg;
        split_next.bright = bright3_reg;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            hue1_reg    <= hsv_in.hue_degrees;
            quot_reg    <= quot_next;
            sat1_reg    <= sat_next;
            bright1_reg <= bright_next;
        end
        if (rdy2)
        begin
            hue2_reg    <= hue2_next;
            sat2_reg    <= sat1_reg;
            bright2_reg <= bright1_reg;
        end
        if (rdy3)
        begin
            hue3_reg    <= hue2_reg;
            sector3_reg <= sector_next;
            sat3_reg    <= sat2_reg;
            bright3_reg <= bright2_reg;
        end
        if (rdy4)
        begin
            split_reg <= split_next;
        end
    end

    assign split_valid = vld4_reg;
    assign split_data  = split_reg;

    // reduced hue stays below a full turn
    a_hue_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        vld2_reg |-> (hue2_reg < HUE_TURN))
        else $error("hue reduction out of range");

    // sector estimate is a valid sector and does not lie above the reduced hue
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld3_reg |-> (sector3_reg == SEC_RED_YEL || sector3_reg == SEC_YEL_GRN ||
                      sector3_reg == SEC_GRN_CYN || sector3_reg == SEC_CYN_BLU ||
                      sector3_reg == SEC_BLU_MAG || sector3_reg == SEC_MAG_RED)
                     && (9'(sector3_reg) * 9'(SECTOR_DEG) <= hue3_reg))
        else $error("sector estimate above reduced hue");

    // remainder within one sector
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld4_reg |-> (split_reg.frac < SECTOR_DEG))
        else $error("sector remainder out of range");

endmodule

@@ rtl/hsv_mix.sv @@
// two stage forming of p, q, t, v numerators and sector selection
module hsv_mix
    import hsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       split_valid,
    output logic       split_ready,
    input  hsv_split_t split_data,
    output logic       num_valid,
    input  logic       num_ready,
    output rgb_num_t   num_data
);

    logic vld1_reg, vld2_reg;
    logic rdy1, rdy2;

    logic [13:0] xp_reg, xq_reg, xt_reg;
    sector_t     sector_reg;
    level_t      bright_reg;
    rgb_num_t    num_reg;
    num_t        top_num_reg;

    logic [14:0] sm_q, sm_t, sm_p;
    logic [14:0] xq_full, xt_full, xp_full;
    num_t        nv, np, nq, nt;
    rgb_num_t    num_next;

    assign rdy2 = !vld2_reg || num_ready;
    assign rdy1 = !vld1_reg || rdy2;
    assign split_ready = rdy1;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                vld1_reg <= split_valid;
            end
            if (rdy2)
            begin
                vld2_reg <= vld1_reg;
            end
        end
    end

    // stage 1: 1 - s*f, 1 - s*(1-f), 1 - s, all times 256*60
    assign sm_q = 15'(split_data.sat) * 15'(split_data.frac);
    assign sm_t = 15'(split_data.sat) * 15'(SECTOR_DEG - split_data.frac);
    assign sm_p = 15'(split_data.sat) * 15'(SECTOR_DEG);
    assign xq_full = 15'(FULL_NUM) - sm_q;
    assign xt_full = 15'(FULL_NUM) - sm_t;
    assign xp_full = 15'(FULL_NUM) - sm_p;

    // stage 2: scale by brightness and route by sector
    assign nv = 22'(bright_reg) * 22'(FULL_NUM);
    assign np = 22'(bright_reg) * 22'(xp_reg);
    assign nq = 22'(bright_reg) * 22'(xq_reg);
    assign nt = 22'(bright_reg) * 22'(xt_reg);

    always_comb
    begin
        case (sector_reg)
            SEC_RED_YEL:
            begin
                num_next.red_num   = nv;
                num_next.green_num = nt;
                num_next.blue_num  = np;
            end
            SEC_YEL_GRN:
            begin
                num_next.red_num   = nq;
                num_next.green_num = nv;
                num_next.blue_num  = np;
            end
            SEC_GRN_CYN:
            begin
                num_next.red_num   = np;
                num_next.green_num = nv;
                num_next.blue_num  = nt;
            end
            SEC_CYN_BLU:
            begin
                num_next.red_num   = np;
                num_next.green_num = nq;
                num_next.blue_num  = nv;
            end
            SEC_BLU_MAG:
            begin
                num_next.red_num   = nt;
                num_next.green_num = np;
                num_next.blue_num  = nv;
            end
            default:
            begin
                num_next.red_num   = nv;
                num_next.green_num = np;
                num_next.blue_num  = nq;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            xq_reg     <= xq_full[13:0];
            xt_reg     <= xt_full[13:0];
            xp_reg     <= xp_full[13:0];
            sector_reg <= split_data.sector;
            bright_reg <= split_data.bright;
        end
        if (rdy2)
        begin
            num_reg     <= num_next;
            top_num_reg <= nv;
        end
    end

    assign num_valid = vld2_reg;
    assign num_data  = num_reg;

    // numerators never exceed the common denominator
    a_num_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld2_reg |-> (num_reg.red_num <= MAX_NUM && num_reg.green_num <= MAX_NUM &&
                      num_reg.blue_num <= MAX_NUM))
        else $error("component numerator above one");

    // every sector routes the brightness to one component
    a_bright_routed: assert property (@(posedge clk) disable iff (!rst_n)
        vld2_reg |-> (num_reg.red_num == top_num_reg ||
                      num_reg.green_num == top_num_reg ||
                      num_reg.blue_num == top_num_reg))
        else $error("brightness not routed to any component");

endmodule

@@ rtl/hsv_scale.sv @@
// two stage scaling of numerators to 5/6/5 bits with truncation
module hsv_scale
    import hsv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     num_valid,
    output logic     num_ready,
    input  rgb_num_t num_data,
    rgb_out_if.source rgb_out
);

    logic vld1_reg, vld2_reg;
    logic rdy1, rdy2;

    logic [8:0] ar_reg, ab_reg;
    logic [9:0] ag_reg;
    logic [4:0] red_reg, blue_reg;
    logic [5:0] green_reg;

    logic [26:0] r_scaled, b_scaled;
    logic [27:0] g_scaled;
    logic [21:0] r_quot, b_quot;
    logic [22:0] g_quot;

    assign rdy2 = !vld2_reg || rgb_out.ready;
    assign rdy1 = !vld1_reg || rdy2;
    assign num_ready = rdy1;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                vld1_reg <= num_valid;
            end
            if (rdy2)
            begin
                vld2_reg <= vld1_reg;
            end
        end
    end

    // stage 1: times scale, then drop the power of two part of the denominator
    assign r_scaled = 27'(num_data.red_num) * 27'(SCALE5);
    assign g_scaled = 28'(num_data.green_num) * 28'(SCALE6);
    assign b_scaled = 27'(num_data.blue_num) * 27'(SCALE5);

    // stage 2: remaining divide by 15 through the reciprocal
    assign r_quot = 22'(ar_reg) * 22'(DIV15_RECIP);
    assign g_quot = 23'(ag_reg) * 23'(DIV15_RECIP);
    assign b_quot = 22'(ab_reg) * 22'(DIV15_RECIP);

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            ar_reg <= r_scaled[26:18];
            ag_reg <= g_scaled[27:18];
            ab_reg <= b_scaled[26:18];
        end
        if (rdy2)
        begin
            red_reg   <= r_quot[20:16];
            green_reg <= g_quot[21:16];
            blue_reg  <= b_quot[20:16];
        end
    end

    assign rgb_out.valid = vld2_reg;
    assign rgb_out.red   = red_reg;
    assign rgb_out.green = green_reg;
    assign rgb_out.blue  = blue_reg;

endmodule

@@ rtl/hsv_to_rgb565.sv @@
// hsv to rgb565 converter, top level
// the path runs through the hue split, mix and scale stages, each of them registered
// throughput: one colour per cycle while the output is not stalled; every stage has its own valid bit and
// loads whenever it is empty or its contents move on, so bubbles close up
// reset clears only the valid bits; the datapath registers are not reset
module hsv_to_rgb565
    import hsv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hsv_in_if.sink    hsv_in,
    rgb_out_if.source rgb_out
);

    logic       split_valid;
    logic       split_ready;
    hsv_split_t split_data;
    logic       num_valid;
    logic       num_ready;
    rgb_num_t   num_data;

    // hue reduction and sector split
    hsv_hue_split u_split (
        .clk         (clk),
        .rst_n       (rst_n),
        .hsv_in      (hsv_in),
        .split_valid (split_valid),
        .split_ready (split_ready),
        .split_data  (split_data)
    );

    // p, q, t, v numerators and sector routing
    hsv_mix u_mix (
        .clk         (clk),
        .rst_n       (rst_n),
        .split_valid (split_valid),
        .split_ready (split_ready),
        .split_data  (split_data),
        .num_valid   (num_valid),
        .num_ready   (num_ready),
        .num_data    (num_data)
    );

    // scaling to 5/6/5 bits and output register
    hsv_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num_data  (num_data),
        .rgb_out   (rgb_out)
    );

endmodule

@@ sim/testbench.sv @@
// testbench for the hsv to rgb565 converter: directed table, random colours, self-checking
`timescale 1ns / 100ps

module testbench
    import hsv_pkg::*;
();

    // fixed-point constants of the conversion
    localparam int unsigned TURN_DEG   = 360;
    localparam int unsigned SIXTY_DEG  = 60;
    localparam int unsigned UNIT_LEVEL = 256;
    localparam int unsigned UNIT_NUM   = UNIT_LEVEL * SIXTY_DEG;
    localparam longint unsigned DENOM  = 64'd3932160;
    localparam int unsigned NUM_RANDOM = 450;
    localparam int unsigned NUM_ROWS   = 22;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic [4:0] red;
        logic [5:0] green;
        logic [4:0] blue;
    } rgb565_t;

    // one row of directed stimulus, with the colour typed in where it is obvious
    typedef struct packed {
        logic [15:0] hue;
        logic [8:0]  sat;
        logic [8:0]  bright;
        logic        known;
        rgb565_t     colour;
    } colour_row_t;

    localparam colour_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
        // pure primaries and secondaries at full saturation and brightness
        '{16'd0,     9'd256, 9'd256, 1'b1, '{5'd31, 6'd0,  5'd0}},
        '{16'd120,   9'd256, 9'd256, 1'b1, '{5'd0,  6'd63, 5'd0}},
        '{16'd240,   9'd256, 9'd256, 1'b1, '{5'd0,  6'd0,  5'd31}},
        '{16'd60,    9'd256, 9'd256, 1'b1, '{5'd31, 6'd63, 5'd0}},
        '{16'd180,   9'd256, 9'd256, 1'b1, '{5'd0,  6'd63, 5'd31}},
        '{16'd300,   9'd256, 9'd256, 1'b1, '{5'd31, 6'd0,  5'd31}},
        // white and black
        '{16'd0,     9'd0,   9'd256, 1'b1, '{5'd31, 6'd63, 5'd31}},
        '{16'd0,     9'd0,   9'd0,   1'b1, '{5'd0,  6'd0,  5'd0}},
        '{16'd65535, 9'd511, 9'd0,   1'b1, '{5'd0,  6'd0,  5'd0}},
        // hue wrapping onto zero
        '{16'd360,   9'd256, 9'd256, 1'b1, '{5'd31, 6'd0,  5'd0}},
        '{16'd65520, 9'd256, 9'd256, 1'b1, '{5'd31, 6'd0,  5'd0}},
        // levels above one saturate
        '{16'd0,     9'd511, 9'd256, 1'b1, '{5'd31, 6'd0,  5'd0}},
        '{16'd200,   9'd0,   9'd511, 1'b1, '{5'd31, 6'd63, 5'd31}},
        // remaining rows go through the predictor
        '{16'd65535, 9'd256, 9'd256, 1'b0, '0},
        '{16'd59,    9'd256, 9'd256, 1'b0, '0},
        '{16'd359,   9'd256, 9'd256, 1'b0, '0},
        '{16'd90,    9'd128, 9'd200, 1'b0, '0},
        '{16'd30,    9'd256, 9'd128, 1'b0, '0},
        '{16'd150,   9'd300, 9'd300, 1'b0, '0},
        '{16'd210,   9'd1,   9'd1,   1'b0, '0},
        '{16'd270,   9'd255, 9'd255, 1'b0, '0},
        '{16'd330,   9'd100, 9'd256, 1'b0, '0}
    };

    logic clk;
    logic rst_n;
    logic steady_run;
    int unsigned fault_count;
    rgb565_t pending_colours [$];

    hsv_in_if  hsv_in ();
    rgb_out_if rgb_out ();

    hsv_to_rgb565 dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .hsv_in  (hsv_in.sink),
        .rgb_out (rgb_out.source)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // hsv to rgb565 conversion with exact numerators and one truncation
    function automatic rgb565_t convert_hsv(logic [15:0] hue, logic [8:0] sat,
                                            logic [8:0] bright);
        int unsigned h;
        int unsigned s;
        int unsigned v;
        int unsigned m;
        sector_t sec;
        longint unsigned nv;
        longint unsigned np;
        longint unsigned nq;
        longint unsigned nt;
        longint unsigned nr;
        longint unsigned ng;
        longint unsigned nb;
        rgb565_t res;
        h = int'(hue) % TURN_DEG;
        s = (sat > UNIT_LEVEL) ? UNIT_LEVEL : int'(sat);
        v = (bright > UNIT_LEVEL) ? UNIT_LEVEL : int'(bright);
        sec = sector_t'(h / SIXTY_DEG);
        m = h % SIXTY_DEG;
        nv = longint'(v) * UNIT_NUM;
        np = longint'(v) * ((UNIT_LEVEL - s) * SIXTY_DEG);
        nq = longint'(v) * (UNIT_NUM - s * m);
        nt = longint'(v) * (UNIT_NUM - s * (SIXTY_DEG - m));
        case (sec)
            SEC_RED_YEL:
            begin
                nr = nv;
                ng = nt;
                nb = np;
            end
            SEC_YEL_GRN:
            begin
                nr = nq;
                ng = nv;
                nb = np;
            end
            SEC_GRN_CYN:
            begin
                nr = np;
                ng = nv;
                nb = nt;
            end
            SEC_CYN_BLU:
            begin
                nr = np;
                ng = nq;
                nb = nv;
            end
            SEC_BLU_MAG:
            begin
                nr = nt;
                ng = np;
                nb = nv;
            end
            default:
            begin
                nr = nv;
                ng = np;
                nb = nq;
            end
        endcase
        res.red   = 5'((nr * 31) / DENOM);
        res.green = 6'((ng * 63) / DENOM);
        res.blue  = 5'((nb * 31) / DENOM);
        return res;
    endfunction

    // count a fault, report only the first few
    task automatic note_fault(string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // offer one colour and hold it until the transfer, idling at random first
    task automatic send_colour(logic [15:0] hue, logic [8:0] sat, logic [8:0] bright,
                               logic known, rgb565_t typed);
        while (!steady_run && $urandom_range(99) < 7)
        begin
            hsv_in.valid <= 1'b0;
            @(posedge clk);
        end
        hsv_in.valid        <= 1'b1;
        hsv_in.hue_degrees  <= hue;
        hsv_in.sat_level    <= sat;
        hsv_in.bright_level <= bright;
        @(posedge clk);
        while (hsv_in.ready !== 1'b1)
            @(posedge clk);
        pending_colours.push_back(known ? typed : convert_hsv(hue, sat, bright));
    endtask

    // pause the sender until every pending colour has come out
    task automatic drain_colours();
        hsv_in.valid <= 1'b0;
        @(posedge clk);
        while (pending_colours.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random back-pressure and result checking
    always @(posedge clk)
    begin
        rgb565_t want;
        if (rst_n !== 1'b1)
        begin
            rgb_out.ready <= 1'b0;
        end
        else
        begin
            if (rgb_out.valid === 1'b1 && rgb_out.ready === 1'b1)
            begin
                if (pending_colours.size() == 0)
                begin
                    note_fault($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                         rgb_out.red, rgb_out.green, rgb_out.blue));
                end
                else
                begin
                    want = pending_colours.pop_front();
                    if (rgb_out.red !== want.red || rgb_out.green !== want.green ||
                        rgb_out.blue !== want.blue)
                        note_fault($sformatf("expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                             want.red, want.green, want.blue,
                                             rgb_out.red, rgb_out.green, rgb_out.blue));
                end
            end
            rgb_out.ready <= steady_run || ($urandom_range(99) >= 7);
        end
    end

    // overall time limit
    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [15:0] hue;
        logic [8:0]  sat;
        logic [8:0]  bright;
        int unsigned pick;
        fault_count         = 0;
        steady_run          = 1'b0;
        rst_n               <= 1'b0;
        hsv_in.valid        <= 1'b0;
        hsv_in.hue_degrees  <= '0;
        hsv_in.sat_level    <= '0;
        hsv_in.bright_level <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < NUM_ROWS; i++)
            send_colour(DIRECTED_ROWS[i].hue, DIRECTED_ROWS[i].sat, DIRECTED_ROWS[i].bright,
                        DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].colour);
        drain_colours();

        // random colours
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            steady_run = (n >= 150 && n < 260);
            if (n == 300)
                drain_colours();

            // hue: in range, full width, or on a sector boundary
            pick = $urandom_range(99);
            if (pick < 50)
                hue = 16'($urandom_range(TURN_DEG - 1));
            else if (pick < 80)
                hue = 16'($urandom);
            else
                hue = 16'($urandom_range(5) * SIXTY_DEG + ($urandom_range(1) ? 59 : 0)
                          + TURN_DEG * $urandom_range(181));

            // levels: mostly in range, some extremes, some above one
            pick = $urandom_range(99);
            if (pick < 80)
                sat = 9'($urandom_range(UNIT_LEVEL));
            else if (pick < 90)
                sat = $urandom_range(1) ? 9'(UNIT_LEVEL) : 9'd0;
            else
                sat = 9'($urandom_range(511, UNIT_LEVEL + 1));
            pick = $urandom_range(99);
            if (pick < 80)
                bright = 9'($urandom_range(UNIT_LEVEL));
            else if (pick < 90)
                bright = $urandom_range(1) ? 9'(UNIT_LEVEL) : 9'd0;
            else
                bright = 9'($urandom_range(511, UNIT_LEVEL + 1));

            send_colour(hue, sat, bright, 1'b0, '0);
        end
        steady_run = 1'b0;

        // wait for the tail, then watch for stray results
        drain_colours();
        repeat (30) @(posedge clk);
        if (fault_count == 0 && pending_colours.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
